// ===== src/psort_pkg.sv =====
`timescale 1ns / 1ps

package psort_pkg;

    localparam int MAX_PATCHES = 256;
    localparam int POS_W       = $clog2(MAX_PATCHES);
    localparam int CNT_W       = $clog2(MAX_PATCHES + 1);
    localparam int LO_W        = (POS_W + 1) / 2;
    localparam int HI_W        = POS_W - LO_W;
    localparam int GROUP_SIZE  = 2 ** LO_W;
    localparam int NUM_GROUPS  = 2 ** HI_W;

    localparam int OP_W    = 2;
    localparam int INDEX_W = 8;
    localparam int LEVEL_W = 3;
    localparam int DIST_W  = 26;
    localparam int KEY_W   = LEVEL_W + DIST_W;

    typedef enum logic [OP_W-1:0] {
        OP_LOAD  = 2'd0,
        OP_READ  = 2'd1,
        OP_CLEAR = 2'd2
    } op_t;

    typedef struct packed {
        logic [LEVEL_W-1:0] level;
        logic [DIST_W-1:0]  sq_dist;
        logic [INDEX_W-1:0] index;
    } entry_t;

    typedef struct packed {
        logic ins_en;
        logic occupied;
    } cell_ctl_t;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SEL  = 3'b010,
        S_FIN  = 3'b100
    } state_t;

endpackage

// ===== src/psort_cell.sv =====
`timescale 1ns / 1ps

module psort_cell
    import psort_pkg::*;
(
    input  logic      clk,
    input  cell_ctl_t ctl,
    input  entry_t    new_entry,
    input  entry_t    left_entry,
    input  logic      left_take,
    output logic      take,
    output entry_t    entry
);

    entry_t entry_reg;
    entry_t entry_next;
    logic   key_gt;

    // strict compare: an equal key stays ahead of the new item
    assign key_gt = {entry_reg.level, entry_reg.sq_dist} > {new_entry.level, new_entry.sq_dist};
    assign take   = !ctl.occupied || key_gt;

    always_comb
    begin
        entry_next = entry_reg;
        if (ctl.ins_en && take)
        begin
            entry_next = left_take ? left_entry : new_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

// ===== src/psort_sel.sv =====
`timescale 1ns / 1ps

module psort_sel
    import psort_pkg::*;
(
    input  logic             clk,
    input  entry_t           entries [MAX_PATCHES],
    input  logic [POS_W-1:0] pos,
    output entry_t           result
);

    entry_t            grp_reg [NUM_GROUPS];
    entry_t            grp_next [NUM_GROUPS];
    logic [LO_W-1:0]   lo;
    logic [HI_W-1:0]   hi_reg;

    assign lo = pos[LO_W-1:0];

    always_comb
    begin
        for (int g = 0; g < NUM_GROUPS; g++)
        begin
            grp_next[g] = '0;
            for (int j = 0; j < GROUP_SIZE; j++)
            begin
                if ((g * GROUP_SIZE + j) < MAX_PATCHES && lo == LO_W'(j))
                begin
                    grp_next[g] = entries[g * GROUP_SIZE + j];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int g = 0; g < NUM_GROUPS; g++)
        begin
            grp_reg[g] <= grp_next[g];
        end
        hi_reg <= pos[POS_W-1:LO_W];
    end

    assign result = grp_reg[hi_reg];

endmodule

// ===== src/patch_sort_by_level_then_distance.sv =====
`timescale 1ns / 1ps

// channel  handshake           payload
// in       in_valid, in_stall  op, patch_index, detail_level, dist_sq
// out      out_valid, out_stall sorted_index, out_level, is_last, empty_res
//
// A load or clear item leaves the input free for the next item; the insertion chain places a load as it is accepted.
// A read passes the read address register and the registered select tree, then the output
// register; the next item is accepted only once its result has been taken.
// in_stall is high while a read is in flight or a result waits.
// Reset clears the entry count, read position, state and output valid; no clearing pass.
// A load into a full store is dropped.

module patch_sort_by_level_then_distance
    import psort_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [OP_W-1:0]    op,
    input  logic [INDEX_W-1:0] patch_index,
    input  logic [LEVEL_W-1:0] detail_level,
    input  logic [DIST_W-1:0]  dist_sq,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [INDEX_W-1:0] sorted_index,
    output logic [LEVEL_W-1:0] out_level,
    output logic               is_last,
    output logic               empty_res
);

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [CNT_W-1:0]   rp_reg, rp_next;
    logic [POS_W-1:0]   rd_pos_reg;
    logic               empty_pend_reg;
    logic               last_pend_reg;
    logic               out_valid_reg, out_valid_next;
    logic [INDEX_W-1:0] sorted_index_reg;
    logic [LEVEL_W-1:0] out_level_reg;
    logic               is_last_reg;
    logic               empty_res_reg;

    logic   in_acc;
    logic   do_load;
    logic   do_read;
    logic   rd_empty;
    op_t    op_code;
    entry_t new_entry;
    entry_t sel_result;
    entry_t cell_entry [MAX_PATCHES];
    logic   cell_take  [MAX_PATCHES];

    assign in_stall  = (state_reg != S_IDLE) || out_valid_reg;
    assign in_acc    = in_valid && !in_stall;
    assign op_code   = op_t'(op);
    assign do_load   = in_acc && (op_code == OP_LOAD) && (count_reg < CNT_W'(MAX_PATCHES));
    assign do_read   = in_acc && (op_code == OP_READ);
    assign rd_empty  = !(rp_reg < count_reg);
    assign new_entry = '{level: detail_level, sq_dist: dist_sq, index: patch_index};

    for (genvar i = 0; i < MAX_PATCHES; i++)
    begin : g_cell
        cell_ctl_t ctl;
        assign ctl.ins_en   = do_load;
        assign ctl.occupied = CNT_W'(i) < count_reg;
        if (i == 0)
        begin : g_head
            psort_cell u_cell (
                .clk        (clk),
                .ctl        (ctl),
                .new_entry  (new_entry),
                .left_entry (new_entry),
                .left_take  (1'b0),
                .take       (cell_take[i]),
                .entry      (cell_entry[i])
            );
        end
        else
        begin : g_body
            psort_cell u_cell (
                .clk        (clk),
                .ctl        (ctl),
                .new_entry  (new_entry),
                .left_entry (cell_entry[i-1]),
                .left_take  (cell_take[i-1]),
                .take       (cell_take[i]),
                .entry      (cell_entry[i])
            );
        end
    end

    psort_sel u_sel (
        .clk     (clk),
        .entries (cell_entry),
        .pos     (rd_pos_reg),
        .result  (sel_result)
    );

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        rp_next    = rp_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    case (op_code)
                        OP_LOAD:
                        begin
                            if (do_load)
                            begin
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        OP_READ:
                        begin
                            state_next = S_SEL;
                            if (!rd_empty)
                            begin
                                rp_next = rp_reg + CNT_W'(1);
                            end
                        end
                        OP_CLEAR:
                        begin
                            count_next = '0;
                            rp_next    = '0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_SEL:   state_next = S_FIN;
            S_FIN:   state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        if (state_reg == S_FIN)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            rp_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rp_reg        <= rp_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_read)
        begin
            rd_pos_reg     <= rp_reg[POS_W-1:0];
            empty_pend_reg <= rd_empty;
            last_pend_reg  <= (rp_reg + CNT_W'(1)) == count_reg;
        end
        if (state_reg == S_FIN)
        begin
            sorted_index_reg <= empty_pend_reg ? '0 : sel_result.index;
            out_level_reg    <= empty_pend_reg ? '0 : sel_result.level;
            is_last_reg      <= !empty_pend_reg && last_pend_reg;
            empty_res_reg    <= empty_pend_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign sorted_index = sorted_index_reg;
    assign out_level    = out_level_reg;
    assign is_last      = is_last_reg;
    assign empty_res    = empty_res_reg;

    a_rp_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rp_reg <= count_reg)
        else $error("read position beyond entry count");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_PATCHES))
        else $error("entry count beyond capacity");

    a_full_drop: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && op_code == OP_LOAD && count_reg == CNT_W'(MAX_PATCHES))
        |=> $stable(count_reg))
        else $error("load into full store changed count");

    a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_FIN))
        else $error("result raised outside final read stage");

    a_read_busy: assert property (@(posedge clk) disable iff (!rst_n)
        do_read |=> (state_reg == S_SEL) && in_stall)
        else $error("read did not enter select stage");

endmodule

// ===== tb/patch_sort_by_level_then_distance_tb.sv =====
`timescale 1ns / 1ps

module patch_sort_by_level_then_distance_tb;
    import psort_pkg::*;

    localparam logic [OP_W-1:0]   OP_IGNORED   = 2'd3;
    localparam logic [DIST_W-1:0] DIST_MAX     = {DIST_W{1'b1}};
    localparam int                CYCLE_LIMIT  = 200000;
    localparam int                DRAIN_CYCLES = 10;
    localparam int                RANDOM_ITEMS = 950;
    localparam int                REPORT_LIMIT = 10;

    typedef struct packed {
        logic [KEY_W-1:0]   key;
        logic [INDEX_W-1:0] index;
    } slot_t;

    typedef struct packed {
        logic [INDEX_W-1:0] index;
        logic [LEVEL_W-1:0] level;
        logic               last;
        logic               empty;
    } readout_t;

    logic               clk          = 1'b0;
    logic               rst_n        = 1'b0;
    logic               in_valid     = 1'b0;
    logic               in_stall;
    logic [OP_W-1:0]    op           = OP_LOAD;
    logic [INDEX_W-1:0] patch_index  = '0;
    logic [LEVEL_W-1:0] detail_level = '0;
    logic [DIST_W-1:0]  dist_sq      = '0;
    logic               out_valid;
    logic               out_stall    = 1'b0;
    logic [INDEX_W-1:0] sorted_index;
    logic [LEVEL_W-1:0] out_level;
    logic               is_last;
    logic               empty_res;

    slot_t    sorted_store [MAX_PATCHES];
    int       stored_count = 0;
    int       read_pos     = 0;
    readout_t expected_reads [$];

    int idle_pct        = 17;
    int stall_pct       = 17;
    int cycle_count     = 0;
    int mismatches      = 0;
    int loads_done      = 0;
    int drops_done      = 0;
    int reads_done      = 0;
    int clears_done     = 0;
    int ignored_done    = 0;
    int results_checked = 0;

    patch_sort_by_level_then_distance dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .op           (op),
        .patch_index  (patch_index),
        .detail_level (detail_level),
        .dist_sq      (dist_sq),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .sorted_index (sorted_index),
        .out_level    (out_level),
        .is_last      (is_last),
        .empty_res    (empty_res)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic void place_entry(logic [INDEX_W-1:0] idx, logic [LEVEL_W-1:0] lvl,
                                        logic [DIST_W-1:0] sq_dist);
        int pos;
        logic [KEY_W-1:0] new_key;
        new_key = {lvl, sq_dist};
        if (stored_count >= MAX_PATCHES)
        begin
            drops_done++;
            return;
        end
        pos = stored_count;
        // equal keys stay behind the entries already held
        while (pos > 0 && sorted_store[pos-1].key > new_key)
        begin
            sorted_store[pos] = sorted_store[pos-1];
            pos--;
        end
        sorted_store[pos] = '{key: new_key, index: idx};
        stored_count++;
    endfunction

    function automatic readout_t read_next();
        readout_t r;
        r = '0;
        if (read_pos < stored_count)
        begin
            r.index = sorted_store[read_pos].index;
            r.level = sorted_store[read_pos].key[KEY_W-1 -: LEVEL_W];
            r.last  = (read_pos + 1 == stored_count);
            read_pos++;
        end
        else
        begin
            r.empty = 1'b1;
        end
        return r;
    endfunction

    function automatic logic [LEVEL_W-1:0] pick_level();
        if ($urandom_range(4) == 0)
            return LEVEL_W'($urandom_range(7));
        return LEVEL_W'($urandom_range(4));
    endfunction

    function automatic logic [DIST_W-1:0] pick_dist();
        case ($urandom_range(5))
            0:       return '0;
            1:       return DIST_MAX;
            2, 3:    return DIST_W'($urandom_range(7));
            default: return DIST_W'($urandom());
        endcase
    endfunction

    function automatic void note_mismatch(string what, readout_t want, readout_t got);
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
        begin
            $display("%0t: %s: expected index %0d level %0d last %0b empty %0b",
                     $time, what, want.index, want.level, want.last, want.empty);
            $display("    got index %0d level %0d last %0b empty %0b",
                     got.index, got.level, got.last, got.empty);
        end
    endfunction

    task automatic send_item(logic [OP_W-1:0] code, logic [INDEX_W-1:0] idx = '0,
                             logic [LEVEL_W-1:0] lvl = '0, logic [DIST_W-1:0] sq_dist = '0);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid     <= 1'b1;
        op           <= code;
        patch_index  <= idx;
        detail_level <= lvl;
        dist_sq      <= sq_dist;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        case (code)
            OP_LOAD:
            begin
                place_entry(idx, lvl, sq_dist);
                loads_done++;
            end
            OP_READ:
            begin
                expected_reads.insert(expected_reads.size(), read_next());
                reads_done++;
            end
            OP_CLEAR:
            begin
                stored_count = 0;
                read_pos     = 0;
                clears_done++;
            end
            default:
                ignored_done++;
        endcase
    endtask

    task automatic send_random_load();
        send_item(OP_LOAD, INDEX_W'($urandom_range(255)), pick_level(), pick_dist());
    endtask

    task automatic test_directed();
        send_item(OP_CLEAR);
        send_item(OP_READ);
        send_item(OP_LOAD, 8'd255, 3'd7, DIST_MAX);
        send_item(OP_LOAD, 8'd0, 3'd0, '0);
        send_item(OP_LOAD, 8'd17, 3'd2, 26'd100);
        send_item(OP_LOAD, 8'd18, 3'd2, 26'd100);
        send_item(OP_LOAD, 8'd19, 3'd2, 26'd99);
        send_item(OP_LOAD, 8'd20, 3'd5, 26'd0);
        send_item(OP_LOAD, 8'd21, 3'd4, DIST_MAX);
        send_item(OP_IGNORED, 8'hAA, 3'd1, 26'd1);
        send_item(OP_LOAD, 8'd22, 3'd6, 26'h155_5555);
        repeat (4) send_item(OP_READ);
        // land one behind the read position and one ahead of it
        send_item(OP_LOAD, 8'd23, 3'd0, 26'd5);
        send_item(OP_LOAD, 8'd24, 3'd7, 26'd0);
        repeat (8) send_item(OP_READ);
        send_item(OP_CLEAR);
        send_item(OP_READ);
    endtask

    task automatic test_full_store();
        send_item(OP_CLEAR);
        repeat (MAX_PATCHES + 2) send_random_load();
        repeat (MAX_PATCHES + 1) send_item(OP_READ);
    endtask

    task automatic test_random();
        int start;
        int progress;
        int n;
        start    = loads_done + reads_done + clears_done;
        progress = 0;
        while (progress < RANDOM_ITEMS)
        begin
            // hold a calm stretch with no idling on either side
            if (progress >= RANDOM_ITEMS / 3 && progress < RANDOM_ITEMS / 2)
            begin
                idle_pct  = 0;
                stall_pct = 0;
            end
            else
            begin
                idle_pct  = 17;
                stall_pct = 17;
            end
            if ($urandom_range(9) == 0)
            begin
                repeat ($urandom_range(1, 12))
                    send_item(OP_W'($urandom_range(3)), INDEX_W'($urandom_range(255)),
                              pick_level(), pick_dist());
            end
            else
            begin
                if ($urandom_range(7) != 0)
                    send_item(OP_CLEAR);
                n = ($urandom_range(9) == 0) ? $urandom_range(25, 120) : $urandom_range(1, 24);
                repeat (n)
                begin
                    if ($urandom_range(19) == 0)
                        send_item(OP_IGNORED, INDEX_W'($urandom()), pick_level(), pick_dist());
                    send_random_load();
                end
                repeat (n + $urandom_range(0, 2))
                begin
                    if ($urandom_range(11) == 0)
                        send_random_load();
                    send_item(OP_READ);
                end
            end
            progress = loads_done + reads_done + clears_done - start;
        end
        idle_pct  = 17;
        stall_pct = 17;
    endtask

    always @(posedge clk)
        out_stall <= ($urandom_range(99) < stall_pct);

    always @(posedge clk)
    begin : check_reads
        readout_t want;
        readout_t got;
        got = '{index: sorted_index, level: out_level, last: is_last, empty: empty_res};
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_reads.size() == 0)
            begin
                note_mismatch("result with no read pending", '0, got);
            end
            else
            begin
                want = expected_reads.pop_front();
                results_checked++;
                if (want !== got)
                    note_mismatch("result mismatch", want, got);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, expected_reads.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_full_store();
        test_random();
        in_valid <= 1'b0;
        while (expected_reads.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Sent %0d loads (%0d dropped when full), %0d reads, %0d clears, %0d ignored",
                 loads_done, drops_done, reads_done, clears_done, ignored_done);
        $display("Checked %0d sorted results, %0d mismatches", results_checked, mismatches);
        if (mismatches == 0 && expected_reads.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== sim.f =====
src/psort_pkg.sv
src/psort_cell.sv
src/psort_sel.sv
src/patch_sort_by_level_then_distance.sv
tb/patch_sort_by_level_then_distance_tb.sv
